// ===== design/rc_ppm_frame_sequencer_defines.svh =====
// Assertion macros shared by the PPM frame sequencer RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef RC_PPM_FRAME_SEQUENCER_DEFINES_SVH
`define RC_PPM_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RCPPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcppm: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RCPPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcppm: next-cycle check failed");

`endif

// ===== design/rcppm_pkg.sv =====
// Types and constants for the PPM frame sequencer.
// No dependencies; used by rcppm_out_skid, rc_ppm_frame_sequencer and the testbench.
package rcppm_pkg;

    // Field widths
    localparam int SYNC_W   = 13;
    localparam int STOP_W   = 10;
    localparam int WIDTH_W  = 12;
    localparam int CHIDX_W  = 3;
    localparam int RELOAD_W = 16;
    localparam int TICKS_W  = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIME = 2'd1;

    // Reset values and timing constants (ticks are 1/9 us)
    localparam logic [SYNC_W-1:0]   SYNC_RESET  = 13'd4000;
    localparam logic [STOP_W-1:0]   STOP_RESET  = 10'd300;
    localparam logic [WIDTH_W-1:0]  WIDTH_LO    = 12'd1000;
    localparam logic [WIDTH_W-1:0]  WIDTH_HI    = 12'd1500;
    localparam logic [TICKS_W-1:0]  FRAME_TICKS = 18'd180000;
    localparam logic [TICKS_W-1:0]  CHUNK_MAX   = 18'd60000;

    // Half-slot codes
    localparam logic HALF_PULSE = 1'b0;
    localparam logic HALF_GAP   = 1'b1;

    // Input command codes
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [CHIDX_W-1:0] channel_index;
        logic [WIDTH_W-1:0] channel_width_us;
    } t_in_item;

    typedef struct packed {
        logic                level;
        logic [RELOAD_W-1:0] reload;
    } t_out_item;

endpackage

// ===== design/rcppm_out_skid.sv =====
// Two-entry result buffer: output register plus one skid register.
// Depends on rcppm_pkg (t_out_item) and the assertion macro header.
`include "rc_ppm_frame_sequencer_defines.svh"

module rcppm_out_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rcppm_pkg::t_out_item i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rcppm_pkg::t_out_item o_data
);

    logic                 r_out_v;
    logic                 r_skid_v;
    rcppm_pkg::t_out_item r_out;
    rcppm_pkg::t_out_item r_skid;
    logic                 out_fire;
    logic                 push;

    assign out_fire = r_out_v & i_ready;
    assign push     = i_valid & ~r_skid_v;

    // Take a beat whenever the skid slot is free
    assign o_ready = ~r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_fire) begin
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (r_out_v && !out_fire) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_v <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_v && !out_fire) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    `RCPPM_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `RCPPM_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_v && !i_ready, r_skid_v && $stable(r_skid))

endmodule

// ===== design/rc_ppm_frame_sequencer.sv =====
// PPM frame sequencer top level: slot state machine, channel widths, config.
// Depends on rcppm_pkg, rcppm_out_skid and the assertion macro header.
//
//  channel | signals                               | beat carries
//  --------+---------------------------------------+------------------------------
//  input   | i_in_valid, o_in_ready, i_in_data     | timer event or width write
//  output  | o_out_valid, i_out_ready, o_out_data  | pin level and timer reload
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index,| sync or stop time write
//          | i_cfg_data                            |
//
// One input beat per cycle while the buffer has room; each result is registered.
// The single-cycle path is the slot step, the width mux and one 16-bit times-nine add.
// Reset (synchronous, active low) puts the sequencer at frame end with a full budget.
// A two-entry output buffer keeps input flowing while one result waits; input
// stalls only when both entries are full. Config writes are always taken.
`include "rc_ppm_frame_sequencer_defines.svh"

module rc_ppm_frame_sequencer #(
    parameter int CHANNELS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rcppm_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rcppm_pkg::t_out_item                 o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rcppm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcppm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SW = $clog2(CHANNELS + 2);
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [SW-1:0] SLOT_SYNC = '0;
    localparam logic [SW-1:0] SLOT_LAST = SW'(CHANNELS);
    localparam logic [SW-1:0] SLOT_END  = SW'(CHANNELS + 1);

    logic [SW-1:0]                   r_slot;
    logic [SW-1:0]                   n_slot;
    logic                            r_half;
    logic                            n_half;
    logic [rcppm_pkg::TICKS_W-1:0]   r_ticks;
    logic [rcppm_pkg::TICKS_W-1:0]   n_ticks;
    logic [rcppm_pkg::WIDTH_W-1:0]   r_widths [CHANNELS];
    logic [rcppm_pkg::SYNC_W-1:0]    r_sync;
    logic [rcppm_pkg::STOP_W-1:0]    r_stop;

    logic                            in_fire;
    logic                            ev_fire;
    logic                            wr_fire;
    logic                            level;
    logic [IW-1:0]                   rd_idx;
    logic [IW-1:0]                   wr_idx;
    logic [rcppm_pkg::WIDTH_W-1:0]   width_sel;
    logic [rcppm_pkg::RELOAD_W-1:0]  len16;
    logic [rcppm_pkg::RELOAD_W-1:0]  base16;
    logic [rcppm_pkg::RELOAD_W-1:0]  period;
    rcppm_pkg::t_out_item            result;
    logic                            buf_ready;

    assign in_fire = i_in_valid & buf_ready;
    assign ev_fire = in_fire & (i_in_data.cmd == rcppm_pkg::CMD_EVENT);
    assign wr_fire = in_fire & (i_in_data.cmd == rcppm_pkg::CMD_WRITE);
    assign o_in_ready  = buf_ready;
    assign o_cfg_ready = 1'b1;

    // Step the slot and half state, pick the pin level
    always_comb begin
        n_slot = r_slot;
        n_half = r_half;
        level  = 1'b0;
        if (r_slot <= SLOT_LAST) begin
            if (r_half == rcppm_pkg::HALF_GAP) begin
                n_half = rcppm_pkg::HALF_PULSE;
                level  = 1'b1;
            end else begin
                n_half = rcppm_pkg::HALF_GAP;
                n_slot = r_slot + SW'(1);
            end
        end else if (r_ticks == rcppm_pkg::FRAME_TICKS) begin
            n_slot = SLOT_SYNC;
            n_half = rcppm_pkg::HALF_GAP;
        end
    end

    // Select the slot length for the new state
    assign rd_idx = IW'(n_slot - SW'(1));
    always_comb begin
        width_sel = '0;
        if (int'(rd_idx) < CHANNELS) begin
            width_sel = r_widths[rd_idx];
        end
    end
    assign len16 = (n_slot == SLOT_SYNC) ? 16'(r_sync) : 16'(width_sel);

    // Next period in ticks, wrapping at 16 bits
    always_comb begin
        base16 = (n_half == rcppm_pkg::HALF_GAP) ? (len16 - 16'(r_stop)) : 16'(r_stop);
        period = base16 + {base16[12:0], 3'b000};
        if (n_slot > SLOT_LAST) begin
            period = (r_ticks > rcppm_pkg::CHUNK_MAX) ? 16'(rcppm_pkg::CHUNK_MAX)
                                                      : r_ticks[15:0];
        end
        if (18'(period) >= r_ticks) begin
            n_ticks = rcppm_pkg::FRAME_TICKS;
        end else begin
            n_ticks = r_ticks - 18'(period);
        end
    end

    assign result.level  = level;
    assign result.reload = period - 16'd1;

    // Sequencer state, channel widths and config registers
    assign wr_idx = IW'(i_in_data.channel_index);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SLOT_END;
            r_half  <= rcppm_pkg::HALF_PULSE;
            r_ticks <= rcppm_pkg::FRAME_TICKS;
            r_sync  <= rcppm_pkg::SYNC_RESET;
            r_stop  <= rcppm_pkg::STOP_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                r_widths[i] <= (i >= 1 && i <= 3) ? rcppm_pkg::WIDTH_HI : rcppm_pkg::WIDTH_LO;
            end
        end else begin
            if (ev_fire) begin
                r_slot  <= n_slot;
                r_half  <= n_half;
                r_ticks <= n_ticks;
            end
            if (wr_fire && (int'(i_in_data.channel_index) < CHANNELS)) begin
                r_widths[wr_idx] <= i_in_data.channel_width_us;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rcppm_pkg::CFG_SYNC_TIME: r_sync <= i_cfg_data[rcppm_pkg::SYNC_W-1:0];
                    rcppm_pkg::CFG_STOP_TIME: r_stop <= i_cfg_data[rcppm_pkg::STOP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result buffer toward the timer
    rcppm_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ev_fire),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    `RCPPM_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, 1'b1, r_slot <= SLOT_END)
    `RCPPM_ASSERT_NOW(a_budget_range, i_clk, i_rst_n, 1'b1, r_ticks != '0 && r_ticks <= rcppm_pkg::FRAME_TICKS)
    `RCPPM_ASSERT_NEXT(a_frame_start, i_clk, i_rst_n, ev_fire && r_slot == SLOT_END && r_ticks == rcppm_pkg::FRAME_TICKS, r_slot == SLOT_SYNC && r_half == rcppm_pkg::HALF_GAP)
    `RCPPM_ASSERT_NEXT(a_gap_to_pulse, i_clk, i_rst_n, ev_fire && r_slot <= SLOT_LAST && r_half == rcppm_pkg::HALF_GAP, r_half == rcppm_pkg::HALF_PULSE && $stable(r_slot))

endmodule

// ===== test/rc_ppm_frame_sequencer_tb.sv =====
// Self-checking testbench for rc_ppm_frame_sequencer: random and directed beats, checked
// against an in-bench model of the slot sequence, pin level and timer reload.
// Depends on rcppm_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module rc_ppm_frame_sequencer_tb;

    localparam int CHANNELS    = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    // Field widths used in casts
    localparam int SYNC_W     = rcppm_pkg::SYNC_W;
    localparam int WIDTH_W    = rcppm_pkg::WIDTH_W;
    localparam int CHIDX_W    = rcppm_pkg::CHIDX_W;
    localparam int TICKS_W    = rcppm_pkg::TICKS_W;
    localparam int CFG_DATA_W = rcppm_pkg::CFG_DATA_W;

    localparam logic [3:0] SLOT_SYNC = 4'd0;
    localparam logic [3:0] SLOT_END  = 4'(CHANNELS + 1);

    // Register indexes with no register behind them
    localparam logic [rcppm_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [rcppm_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_ready;
    rcppm_pkg::t_in_item              i_in_data   = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    rcppm_pkg::t_out_item             o_out_data;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [rcppm_pkg::CFG_IDX_W-1:0]  i_cfg_index = rcppm_pkg::CFG_SYNC_TIME;
    logic [CFG_DATA_W-1:0]            i_cfg_data  = '0;

    // Sequencer model state and its copy of the registers
    logic [SYNC_W-1:0]            cfg_sync_us;
    logic [rcppm_pkg::STOP_W-1:0] cfg_stop_us;
    logic [3:0]                   seq_slot;
    logic                         seq_half;
    logic [TICKS_W-1:0]           budget;
    logic [WIDTH_W-1:0]           ch_width [CHANNELS];

    rcppm_pkg::t_in_item  beats_queued [$];
    rcppm_pkg::t_out_item timer_plan [$];

    int  in_gap_max  = 0;
    int  out_gap_max = 0;
    bit  hold_req    = 1'b0;
    int  mismatches  = 0;
    int  cycle_count = 0;

    rc_ppm_frame_sequencer #(.CHANNELS(CHANNELS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Ticks of the current half slot; wraps modulo 2^16 like the hardware
    function automatic logic [15:0] half_ticks(input logic [SYNC_W-1:0] len_us);
        logic [31:0] t;
        if (seq_half == rcppm_pkg::HALF_GAP) begin
            t = (32'(len_us) - 32'(cfg_stop_us)) * 32'd9;
        end else begin
            t = 32'(cfg_stop_us) * 32'd9;
        end
        return t[15:0];
    endfunction

    // Step the slot machine on a timer event and return pin level and reload
    function automatic rcppm_pkg::t_out_item ppm_advance();
        rcppm_pkg::t_out_item r;
        logic                 lvl;
        logic [TICKS_W-1:0]   period;
        if (seq_slot <= CHANNELS) begin
            if (seq_half == rcppm_pkg::HALF_GAP) begin
                seq_half = rcppm_pkg::HALF_PULSE;
                lvl = 1'b1;
            end else begin
                seq_half = rcppm_pkg::HALF_GAP;
                seq_slot = seq_slot + 4'd1;
                if (seq_slot > CHANNELS) seq_slot = SLOT_END;
                lvl = 1'b0;
            end
        end else begin
            // a new frame starts only once the budget is full again
            if (budget == rcppm_pkg::FRAME_TICKS) begin
                seq_slot = SLOT_SYNC;
                seq_half = rcppm_pkg::HALF_GAP;
            end
            lvl = 1'b0;
        end
        if (seq_slot == SLOT_SYNC) begin
            period = TICKS_W'(half_ticks(cfg_sync_us));
        end else if (seq_slot > CHANNELS) begin
            period = (budget > rcppm_pkg::CHUNK_MAX) ? rcppm_pkg::CHUNK_MAX : budget;
        end else begin
            period = TICKS_W'(half_ticks(SYNC_W'(ch_width[seq_slot - 4'd1])));
        end
        if (period >= budget) budget = rcppm_pkg::FRAME_TICKS;
        else budget = budget - period;
        r.level  = lvl;
        r.reload = 16'(period - 1);
        return r;
    endfunction

    // Apply one accepted input beat to the model
    function automatic void absorb_beat(input rcppm_pkg::t_in_item b);
        if (b.cmd == rcppm_pkg::CMD_WRITE) begin
            if (b.channel_index < CHANNELS) ch_width[b.channel_index] = b.channel_width_us;
        end else begin
            timer_plan.push_back(ppm_advance());
        end
    endfunction

    function automatic rcppm_pkg::t_in_item make_beat(input logic cmd,
                                                      input logic [CHIDX_W-1:0] idx,
                                                      input logic [WIDTH_W-1:0] w);
        rcppm_pkg::t_in_item b;
        b.cmd              = cmd;
        b.channel_index    = idx;
        b.channel_width_us = w;
        return b;
    endfunction

    // Mostly events so frames run through; writes lean on realistic widths
    function automatic rcppm_pkg::t_in_item random_beat();
        rcppm_pkg::t_in_item b;
        b.cmd           = ($urandom_range(0, 9) < 3) ? rcppm_pkg::CMD_WRITE
                                                      : rcppm_pkg::CMD_EVENT;
        b.channel_index = CHIDX_W'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0: b.channel_width_us = WIDTH_W'($urandom_range(0, 4095));
            1: b.channel_width_us = WIDTH_W'(cfg_stop_us);
            2: b.channel_width_us = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: b.channel_width_us = WIDTH_W'($urandom_range(800, 2200));
        endcase
        return b;
    endfunction

    function automatic void flag_mismatch(input string what, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
    endfunction

    // Input driver: offer queued beats with random gaps between them
    always @(posedge i_clk) begin
        int  in_wait;
        bit  took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) absorb_beat(i_in_data);
            if (!i_in_valid || took) begin
                if (in_wait > 0) begin
                    in_wait--;
                    i_in_valid <= 1'b0;
                end else if (beats_queued.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= beats_queued.pop_front();
                    in_wait = $urandom_range(0, in_gap_max);
                end
            end
        end
    end

    // Result monitor: check each beat and throttle ready
    always @(posedge i_clk) begin
        rcppm_pkg::t_out_item want;
        bit                   took;
        int                   stall_left;
        int                   hold_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            took = o_out_valid && i_out_ready;
            if (took) begin
                if (timer_plan.size() == 0) begin
                    flag_mismatch("unexpected result, reload", -1, o_out_data.reload);
                end else begin
                    want = timer_plan.pop_front();
                    if (want.level !== o_out_data.level)
                        flag_mismatch("level", want.level, o_out_data.level);
                    if (want.reload !== o_out_data.reload)
                        flag_mismatch("reload", want.reload, o_out_data.reload);
                end
            end
            // long hold-off lets the output buffer fill and back up the input
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (took) stall_left = $urandom_range(0, out_gap_max);
            else if (stall_left > 0) stall_left--;
            if (hold_left > 0) hold_left--;
            i_out_ready <= (stall_left == 0 && hold_left == 0);
        end
    end

    // Write one register and mirror it once the beat is taken
    task automatic write_reg(input logic [rcppm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == rcppm_pkg::CFG_SYNC_TIME) cfg_sync_us = val;
        else if (idx == rcppm_pkg::CFG_STOP_TIME) cfg_stop_us = val[rcppm_pkg::STOP_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until nothing is in flight, then let the pipeline drain
    task automatic settle();
        do @(negedge i_clk);
        while (beats_queued.size() != 0 || i_in_valid || timer_plan.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [SYNC_W-1:0] sync_us,
                             input logic [CFG_DATA_W-1:0] stop_data,
                             input int n, input int in_gaps, input int out_gaps,
                             input bit squeeze);
        write_reg(rcppm_pkg::CFG_SYNC_TIME, CFG_DATA_W'(sync_us));
        write_reg(rcppm_pkg::CFG_STOP_TIME, stop_data);
        @(negedge i_clk);
        in_gap_max  = in_gaps;
        out_gap_max = out_gaps;
        repeat (n) beats_queued.push_back(random_beat());
        if (squeeze) hold_req = 1'b1;
        settle();
    endtask

    initial begin
        cfg_sync_us = rcppm_pkg::SYNC_RESET;
        cfg_stop_us = rcppm_pkg::STOP_RESET;
        seq_slot    = SLOT_END;
        seq_half    = rcppm_pkg::HALF_PULSE;
        budget      = rcppm_pkg::FRAME_TICKS;
        for (int i = 0; i < CHANNELS; i++) begin
            ch_width[i] = (i >= 1 && i <= 3) ? rcppm_pkg::WIDTH_HI : rcppm_pkg::WIDTH_LO;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: wrapped, full-scale and zero-length periods on reset config
        @(negedge i_clk);
        in_gap_max  = 2;
        out_gap_max = 2;
        beats_queued.push_back(make_beat(rcppm_pkg::CMD_WRITE, 3'd0, 12'h000));
        beats_queued.push_back(make_beat(rcppm_pkg::CMD_WRITE, 3'd1, 12'hFFF));
        beats_queued.push_back(make_beat(rcppm_pkg::CMD_WRITE, 3'd2,
                                         WIDTH_W'(rcppm_pkg::STOP_RESET)));
        beats_queued.push_back(make_beat(rcppm_pkg::CMD_WRITE, 3'd6, 12'h555));
        beats_queued.push_back(make_beat(rcppm_pkg::CMD_WRITE, 3'd7, 12'hAAA));
        for (int i = 0; i < 20; i++) begin
            beats_queued.push_back(make_beat(rcppm_pkg::CMD_EVENT, CHIDX_W'(i),
                                             (i % 2) ? 12'hFFF : 12'h000));
        end
        settle();

        // Register extremes, with long receiver hold-offs in two phases
        run_phase(13'd7281, 13'd1000, 150, 5, 5, 1'b1);
        run_phase(13'd0, 13'd0, 130, 0, 0, 1'b0);
        run_phase(13'h1FFF, 13'h1FFF, 130, 5, 0, 1'b0);
        write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom_range(0, 8191)));
        write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom_range(0, 8191)));
        run_phase(rcppm_pkg::SYNC_RESET, CFG_DATA_W'(rcppm_pkg::STOP_RESET), 150, 0, 5, 1'b1);
        for (int p = 0; p < 4; p++) begin
            run_phase(SYNC_W'($urandom_range(0, 8191)), CFG_DATA_W'($urandom_range(0, 8191)),
                      120, $urandom_range(0, 1) ? 5 : 0, $urandom_range(0, 1) ? 5 : 0, 1'b0);
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
